[design/i2a_pkg.sv]
// ----------------------------------------------------------------------------
// Integer to ASCII radix converter: shared definitions
// Types, widths, character codes and the digit glyph function used by the
// converter and its divider.
// ----------------------------------------------------------------------------
package i2a_pkg;

   localparam int RADIX_WIDTH = 5;
   localparam int DIGIT_WIDTH = 4;
   localparam int CHAR_WIDTH  = 7;

   // Quotient bits that the divider resolves in one clock.
   localparam int DIV_BITS_PER_CYCLE = 4;

   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = 5'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = 5'd16;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 7'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 7'h2d;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_READ,
      ST_EMIT
   } i2a_state_type;

   // Status that the divider returns to the sequencer.
   typedef struct packed {
      logic                   done;
      logic [DIGIT_WIDTH-1:0] remainder;
   } i2a_div_status_type;

   // Lower-case ASCII glyph of one digit, 0 to f.
   function automatic logic [CHAR_WIDTH-1:0] digit_glyph(input logic [DIGIT_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] ext;
      ext = CHAR_WIDTH'(d);
      if (d < 4'd10) begin
         return CHAR_ZERO + ext;
      end else begin
         return CHAR_LOWER_A + ext - 7'd10;
      end
   endfunction

endpackage

[design/i2a_divider.sv]
// ----------------------------------------------------------------------------
// Integer to ASCII radix converter: iterative divider
// Divides an unsigned value by a radix of 2 to 16, resolving several
// quotient bits per clock by restoring compare and subtract.
// ----------------------------------------------------------------------------
module i2a_divider #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [VALUE_WIDTH-1:0]              dividend,
   input  logic [i2a_pkg::RADIX_WIDTH-1:0]     divisor,
   output logic [VALUE_WIDTH-1:0]              quotient,
   output i2a_pkg::i2a_div_status_type         status
);
   import i2a_pkg::*;

   localparam int STEPS  = (VALUE_WIDTH + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
   localparam int PAD_W  = STEPS * DIV_BITS_PER_CYCLE;
   localparam int CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic [PAD_W-1:0]       work_ff, work_in;
   logic [DIGIT_WIDTH-1:0] rem_ff, rem_in;
   logic [RADIX_WIDTH-1:0] div_ff, div_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      logic [RADIX_WIDTH-1:0] trial;
      logic [DIGIT_WIDTH-1:0] r;
      logic [PAD_W-1:0]       w;
      r       = rem_ff;
      w       = work_ff;
      // The partial remainder stays below the divisor, so each trial fits in five bits.
      for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
         trial = {r, w[PAD_W-1]};
         w     = {w[PAD_W-2:0], 1'b0};
         if (trial >= div_ff) begin
            trial = trial - div_ff;
            w[0]  = 1'b1;
         end
         r = trial[DIGIT_WIDTH-1:0];
      end

      work_in = work_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = PAD_W'(dividend);
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_W'(STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = w;
         rem_in  = r;
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign quotient         = work_ff[VALUE_WIDTH-1:0];
   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

[design/integer_to_ascii_radix_top.sv]
// ----------------------------------------------------------------------------
// Integer to ASCII radix converter: top level
// Turns one number into its ASCII digits in a chosen radix, one character
// per output item, most significant digit first.
// ----------------------------------------------------------------------------
// Each input item carries a value, a radix and a signed-mode flag. A radix
// below 2 acts as 2 and one above 16 acts as 16. In signed mode a value with
// its top bit set is negated (the most negative value wraps and prints
// correctly) and a minus sign goes out first. Digits use lower-case letters,
// carry no leading zeros, and zero prints as a single '0'; rsp_last marks the
// final character. The block works on one item at a time and holds req_stall
// high until the item's last character has been handed to the output
// register. Digits are produced least significant first by one shared
// divider that resolves four quotient bits per clock. For each digit the
// divider is loaded and then runs ceil(VALUE_WIDTH/4) division steps (eight
// at the default width); the remainder is written into a small digit store.
// The store is then read back from the top, each character by a registered
// read and then an output load, which waits while rsp_stall holds the output
// register. A minus sign, if any, goes out before the digits.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_top #(
   parameter int VALUE_WIDTH       = 32,
   parameter int DIGIT_STORE_DEPTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [VALUE_WIDTH-1:0]              req_value,
   input  logic [i2a_pkg::RADIX_WIDTH-1:0]     req_radix,
   input  logic                                req_signed_mode,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [i2a_pkg::CHAR_WIDTH-1:0]      rsp_character,
   output logic                                rsp_last
);
   import i2a_pkg::*;

   // The counter must hold the depth itself; the store address only has to index below it.
   localparam int CNT_W  = $clog2(DIGIT_STORE_DEPTH + 1);
   localparam int ADDR_W = $clog2(DIGIT_STORE_DEPTH);

   i2a_state_type state_ff, state_in;

   // Digit count: grows while dividing, then counts down while emitting.
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic [RADIX_WIDTH-1:0] radix_ff, radix_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]  rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Digit store, least significant digit at address zero.
   logic [DIGIT_WIDTH-1:0] store_mem [DIGIT_STORE_DEPTH];
   logic [DIGIT_WIDTH-1:0] rd_data_ff;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic                   rd_en;
   logic [CNT_W-1:0]       rd_idx;

   logic                   div_start;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic [RADIX_WIDTH-1:0] div_divisor;
   logic [VALUE_WIDTH-1:0] div_quotient;
   i2a_div_status_type     div_status;

   logic                   req_accept;
   logic                   out_free;
   logic [RADIX_WIDTH-1:0] radix_clamped;
   logic                   req_negative;
   logic [VALUE_WIDTH-1:0] req_magnitude;

   i2a_divider #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_status)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (req_radix < RADIX_MIN) begin
         radix_clamped = RADIX_MIN;
      end else if (req_radix > RADIX_MAX) begin
         radix_clamped = RADIX_MAX;
      end else begin
         radix_clamped = req_radix;
      end
   end

   // Two's complement negation wraps within the value width, which gives the
   // right magnitude for the most negative value as well.
   assign req_negative  = req_signed_mode && req_value[VALUE_WIDTH-1];
   assign req_magnitude = req_negative ? (~req_value + VALUE_WIDTH'(1)) : req_value;

   assign rd_idx  = cnt_ff - CNT_W'(1);
   assign wr_addr = cnt_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      radix_ff    <= radix_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= div_status.remainder;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_idx[ADDR_W-1:0]];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      radix_in     = radix_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_start    = 1'b0;
      div_dividend = div_quotient;
      div_divisor  = radix_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               div_start    = 1'b1;
               div_dividend = req_magnitude;
               div_divisor  = radix_clamped;
               radix_in     = radix_clamped;
               neg_in       = req_negative;
               cnt_in       = '0;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // Each finished division yields one digit; the quotient feeds the next one.
            if (div_status.done) begin
               wr_en  = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
               if (div_quotient != '0) begin
                  div_start = 1'b1;
               end else if (neg_ff) begin
                  state_in = ST_SIGN;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_glyph(rd_data_ff);
               rsp_last_in  = (cnt_ff == CNT_W'(1));
               cnt_in       = rd_idx;
               state_in     = (cnt_ff == CNT_W'(1)) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // An accepted item always starts a division.
   a_accept_starts_divide: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_DIVIDE))
      else $error("accepted item did not start a division");

   // A digit is never written beyond the end of the store.
   a_store_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && div_status.done) |-> (cnt_ff < CNT_W'(DIGIT_STORE_DEPTH)))
      else $error("digit store write out of range");

   // The least significant digit goes out marked last and frees the input side.
   a_last_digit_marked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && cnt_ff == CNT_W'(1))
         |=> (rsp_valid && rsp_last && state_ff == ST_IDLE))
      else $error("final digit not marked last");

   // The divider only reports a result while the sequencer is collecting digits.
   a_done_only_dividing: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide phase");

endmodule
